// ===== design/yuv420_planar_to_rgb_macros.svh =====
// Assertion macros for the YUV 4:2:0 to RGB converter.
`ifndef YUV420_PLANAR_TO_RGB_MACROS_SVH
`define YUV420_PLANAR_TO_RGB_MACROS_SVH

`ifndef ASSERT_OFF
`define Y4R_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("y4r same-cycle check failed");
`define Y4R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("y4r next-cycle check failed");
`else
`define Y4R_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define Y4R_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/y4r_pkg.sv =====
// Shared constants and types for the YUV 4:2:0 to RGB converter.
`default_nettype none

package y4r_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int CFG_W = 13;
	localparam int CMP_W = 15;
	localparam int PIX_W = 8;
	localparam int CHR_W = 16;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

	localparam int PROD_W    = 19;
	localparam int FRAC_BITS = 10;
	localparam int COEF_RV   = 1436;
	localparam int COEF_GU   = 352;
	localparam int COEF_GV   = 731;
	localparam int COEF_BU   = 1814;
	localparam int PIX_MAX   = 255;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic odd;
		logic last;
	} pos_t;

endpackage

`default_nettype wire

// ===== design/yuv420_planar_to_rgb.sv =====
// Top level: YUV 4:2:0 luma pairs in, packed RGB888 pairs out.
// Pipeline from input transaction to m_tvalid: line buffer read, products, clamp.
// Throughput: one luma pair per cycle unless m_tready stalls the output; a single stall enable covers all stages.
// Reset: counters and valid bits clear, frame_width 640, frame_height 480;
// the chroma line buffer is not cleared and is filled by even rows.
`default_nettype none

`include "yuv420_planar_to_rgb_macros.svh"

module yuv420_planar_to_rgb #(
	parameter int MAX_WIDTH  = y4r_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = y4r_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // luma_first, luma_second, chroma_u, chroma_v
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // red/green/blue_first, red/green/blue_second
	output logic        m_tlast   // frame_end
);

	localparam int LINE_PAIRS = MAX_WIDTH / 2;
	localparam int CW = $clog2(LINE_PAIRS);
	localparam int PW = y4r_pkg::PIX_W;

	logic [y4r_pkg::CFG_W-1:0] frame_width_q;
	logic [y4r_pkg::CFG_W-1:0] frame_height_q;
	logic                      cfg_wr;

	logic                      adv;
	logic                      s_accept;
	logic [CW-1:0]             col;
	y4r_pkg::pos_t             pos;
	logic [y4r_pkg::CHR_W-1:0] chroma_rd;

	logic                      v_s1;
	logic                      v_s2;
	logic                      odd_s1;
	logic                      end_s1;
	logic                      end_s2;
	logic [PW-1:0]             y0_s1;
	logic [PW-1:0]             y1_s1;
	logic [PW-1:0]             u_s1;
	logic [PW-1:0]             v_s1d;
	logic [PW-1:0]             u_sel;
	logic [PW-1:0]             v_sel;
	logic                      m_tvalid_q;
	logic                      m_tlast_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= y4r_pkg::WIDTH_RST;
			frame_height_q <= y4r_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			case (y4r_pkg::reg_idx_t'(paddr[2]))
				y4r_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[y4r_pkg::CFG_W-1:0];
				y4r_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[y4r_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (y4r_pkg::reg_idx_t'(paddr[2]))
			y4r_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			y4r_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                   prdata = '0;
		endcase
	end

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign s_accept = s_tvalid && adv;

	y4r_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s_accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.col          (col),
		.pos          (pos)
	);

	// even rows store chroma, odd rows read it back at the same column
	y4r_line_buf #(
		.DEPTH (LINE_PAIRS)
	) u_line_buf (
		.clk   (clk),
		.wr_en (s_accept && !pos.odd),
		.rd_en (s_accept && pos.odd),
		.addr  (col),
		.wdata ({s_tdata[23:16], s_tdata[31:24]}),
		.rdata (chroma_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			v_s1       <= s_tvalid;
			v_s2       <= v_s1;
			m_tvalid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y0_s1     <= s_tdata[7:0];
			y1_s1     <= s_tdata[15:8];
			u_s1      <= s_tdata[23:16];
			v_s1d     <= s_tdata[31:24];
			odd_s1    <= pos.odd;
			end_s1    <= pos.last;
			end_s2    <= end_s1;
			m_tlast_q <= end_s2;
		end
	end

	assign u_sel = odd_s1 ? chroma_rd[y4r_pkg::CHR_W-1:PW] : u_s1;
	assign v_sel = odd_s1 ? chroma_rd[PW-1:0]              : v_s1d;

	y4r_color u_color (
		.clk (clk),
		.en  (adv),
		.y0  (y0_s1),
		.y1  (y1_s1),
		.u   (u_sel),
		.v   (v_sel),
		.rgb (m_tdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;

	`Y4R_ASSERT_NEXT(a_wrap_to_origin, clk, arst_n, s_accept && pos.last, col == '0 && !pos.odd)
	`Y4R_ASSERT_NEXT(a_odd_read_tracked, clk, arst_n, s_accept && pos.odd, v_s1 && odd_s1)
	`Y4R_ASSERT_SAME(a_last_at_row_end, clk, arst_n, s_accept && pos.last, col != '0 || frame_width_q < y4r_pkg::CFG_W'(4))

endmodule

`default_nettype wire

// ===== design/y4r_seq.sv =====
// Pair column and row counters with frame-end detection.
`default_nettype none

module y4r_seq #(
	parameter int MAX_WIDTH  = y4r_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = y4r_pkg::MAX_HEIGHT_DEF,
	localparam int LINE_PAIRS = MAX_WIDTH / 2,
	localparam int CW = $clog2(LINE_PAIRS),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [y4r_pkg::CFG_W-1:0]  frame_width,
	input  logic [y4r_pkg::CFG_W-1:0]  frame_height,
	output logic [CW-1:0]              col,
	output y4r_pkg::pos_t              pos
);

	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic [y4r_pkg::CMP_W-1:0]  pairs;
	logic [y4r_pkg::CMP_W-1:0]  rows;
	logic                       col_wrap;
	logic                       row_wrap;

	always_comb begin
		pairs = y4r_pkg::CMP_W'(frame_width[y4r_pkg::CFG_W-1:1]);
		if (pairs == '0) begin
			pairs = y4r_pkg::CMP_W'(1);
		end else if (pairs > y4r_pkg::CMP_W'(LINE_PAIRS)) begin
			pairs = y4r_pkg::CMP_W'(LINE_PAIRS);
		end
		rows = y4r_pkg::CMP_W'(frame_height);
		if (rows == '0) begin
			rows = y4r_pkg::CMP_W'(1);
		end else if (rows > y4r_pkg::CMP_W'(MAX_HEIGHT)) begin
			rows = y4r_pkg::CMP_W'(MAX_HEIGHT);
		end
	end

	assign col_wrap = (y4r_pkg::CMP_W'(col_q) + y4r_pkg::CMP_W'(1)) >= pairs;
	assign row_wrap = (y4r_pkg::CMP_W'(row_q) + y4r_pkg::CMP_W'(1)) >= rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign col      = col_q;
	assign pos.odd  = row_q[0];
	assign pos.last = col_wrap && row_wrap;

endmodule

`default_nettype wire

// ===== design/y4r_line_buf.sv =====
// Chroma line buffer: one U/V entry per pair column, registered read.
`default_nettype none

module y4r_line_buf #(
	parameter int DEPTH = y4r_pkg::MAX_WIDTH_DEF / 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [AW-1:0]              addr,
	input  logic [y4r_pkg::CHR_W-1:0]  wdata,
	output logic [y4r_pkg::CHR_W-1:0]  rdata
);

	logic [y4r_pkg::CHR_W-1:0] mem [DEPTH];
	logic [y4r_pkg::CHR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/y4r_color.sv =====
// BT.601 fixed-point color math: products stage, then offset, add and clamp.
`default_nettype none

module y4r_color (
	input  logic                       clk,
	input  logic                       en,
	input  logic [y4r_pkg::PIX_W-1:0]  y0,
	input  logic [y4r_pkg::PIX_W-1:0]  y1,
	input  logic [y4r_pkg::PIX_W-1:0]  u,
	input  logic [y4r_pkg::PIX_W-1:0]  v,
	output logic [6*y4r_pkg::PIX_W-1:0] rgb
);

	localparam int PW = y4r_pkg::PROD_W;
	localparam int OW = PW - y4r_pkg::FRAC_BITS;
	localparam int SW = y4r_pkg::PIX_W + 2;

	logic signed [y4r_pkg::PIX_W-1:0] du;
	logic signed [y4r_pkg::PIX_W-1:0] dv;
	logic signed [PW-1:0]             du_x;
	logic signed [PW-1:0]             dv_x;

	logic signed [PW-1:0]         r_p_s2;
	logic signed [PW-1:0]         g_p_s2;
	logic signed [PW-1:0]         b_p_s2;
	logic [y4r_pkg::PIX_W-1:0]    y0_s2;
	logic [y4r_pkg::PIX_W-1:0]    y1_s2;

	logic signed [OW-1:0]         r_off;
	logic signed [OW-1:0]         g_off;
	logic signed [OW-1:0]         b_off;

	logic [6*y4r_pkg::PIX_W-1:0]  rgb_q;

	function automatic logic [y4r_pkg::PIX_W-1:0] clamp8(input logic signed [SW-1:0] x);
		logic [y4r_pkg::PIX_W-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > SW'(y4r_pkg::PIX_MAX)) begin
			r = y4r_pkg::PIX_W'(y4r_pkg::PIX_MAX);
		end else begin
			r = x[y4r_pkg::PIX_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [3*y4r_pkg::PIX_W-1:0] pixel(
		input logic [y4r_pkg::PIX_W-1:0] y,
		input logic signed [OW-1:0]      ro,
		input logic signed [OW-1:0]      go,
		input logic signed [OW-1:0]      bo
	);
		logic signed [SW-1:0] ys;
		ys = signed'(SW'(y));
		return {clamp8(ys + SW'(bo)), clamp8(ys - SW'(go)), clamp8(ys + SW'(ro))};
	endfunction

	// u - 128 is u with its top bit flipped, read as signed
	assign du   = signed'({~u[y4r_pkg::PIX_W-1], u[y4r_pkg::PIX_W-2:0]});
	assign dv   = signed'({~v[y4r_pkg::PIX_W-1], v[y4r_pkg::PIX_W-2:0]});
	assign du_x = PW'(du);
	assign dv_x = PW'(dv);

	always_ff @(posedge clk) begin
		if (en) begin
			r_p_s2 <= dv_x * PW'(y4r_pkg::COEF_RV);
			g_p_s2 <= du_x * PW'(y4r_pkg::COEF_GU) + dv_x * PW'(y4r_pkg::COEF_GV);
			b_p_s2 <= du_x * PW'(y4r_pkg::COEF_BU);
			y0_s2  <= y0;
			y1_s2  <= y1;
		end
	end

	// floor shift of a two's-complement product is its upper bits
	assign r_off = r_p_s2[PW-1:y4r_pkg::FRAC_BITS];
	assign g_off = g_p_s2[PW-1:y4r_pkg::FRAC_BITS];
	assign b_off = b_p_s2[PW-1:y4r_pkg::FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_q <= {pixel(y1_s2, r_off, g_off, b_off), pixel(y0_s2, r_off, g_off, b_off)};
		end
	end

	assign rgb = rgb_q;

endmodule

`default_nettype wire
